[sv/sat_pkg.sv]
// Shared types, widths and codes for the summed-area table query unit.
package sat_pkg;

  localparam int SUM_W      = 44;
  localparam int ELEM_IN_W  = 32;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int STATUS_W   = 2;
  localparam int ADDR_MAX_W = 20;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_ELEM_WIDTH = 32;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 2;

  localparam logic [CFG_DATA_W-1:0] RESET_ROWS = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RESET_COLS = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RECT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;

  typedef struct packed {
    logic                  is_load;
    logic [STATUS_W-1:0]   status;
    logic                  has_top;
    logic                  has_left;
    logic [ADDR_MAX_W-1:0] addr0;
    logic [ADDR_MAX_W-1:0] addr1;
    logic [ADDR_MAX_W-1:0] addr2;
    logic [ADDR_MAX_W-1:0] addr3;
    logic [SUM_W-1:0]      run_sum;
  } sat_cmd_t;

endpackage

[sv/sat_fifo.sv]
// Small register-based first-in first-out queue.
module sat_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/sat_front.sv]
// Front end: configuration registers, load position tracking and query classification.
module sat_front #(
  parameter int MAX_ROWS   = sat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = sat_pkg::DEF_MAX_COLS,
  parameter int ELEM_WIDTH = sat_pkg::DEF_ELEM_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sat_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_req_type,
  input  logic signed [sat_pkg::ELEM_IN_W-1:0] in_elem_value,
  input  logic [sat_pkg::COORD_W-1:0]         in_top_row,
  input  logic [sat_pkg::COORD_W-1:0]         in_left_col,
  input  logic [sat_pkg::COORD_W-1:0]         in_bottom_row,
  input  logic [sat_pkg::COORD_W-1:0]         in_right_col,
  output logic                                cmd_push,
  output sat_pkg::sat_cmd_t                   cmd_data,
  input  logic                                cmd_full
);

  import sat_pkg::*;

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  logic [CFG_DATA_W-1:0]       rows_r, rows_nxt;
  logic [CFG_DATA_W-1:0]       cols_r, cols_nxt;
  logic [RW-1:0]               load_row_r, load_row_nxt;
  logic [CW-1:0]               load_col_r, load_col_nxt;
  logic [SUM_W-1:0]            run_r, run_nxt;
  logic                        ready_r, ready_nxt;

  logic [RCW-1:0]              eff_rows;
  logic [CCW-1:0]              eff_cols;
  logic [ELEM_WIDTH-1:0]       elem_low;
  logic [SUM_W+ELEM_WIDTH-1:0] elem_ext;
  logic [SUM_W-1:0]            run_new;
  logic                        accept;
  logic                        col_last;
  logic                        row_last;
  logic                        rect_bad;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full;
  assign accept    = in_push && !cmd_full;
  assign cmd_push  = accept;

  always_comb begin
    if (rows_r == '0) begin
      eff_rows = RCW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      eff_rows = RCW'(MAX_ROWS);
    end else begin
      eff_rows = RCW'(rows_r);
    end
    if (cols_r == '0) begin
      eff_cols = CCW'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      eff_cols = CCW'(MAX_COLS);
    end else begin
      eff_cols = CCW'(cols_r);
    end
  end

  assign elem_low = ELEM_WIDTH'({32'b0, in_elem_value});
  assign elem_ext = {{SUM_W{elem_low[ELEM_WIDTH-1]}}, elem_low};
  assign run_new  = run_r + elem_ext[SUM_W-1:0];
  assign col_last = (32'(load_col_r) + 1 >= 32'(eff_cols));
  assign row_last = (32'(load_row_r) + 1 >= 32'(eff_rows));
  assign rect_bad = (in_top_row > in_bottom_row) || (in_left_col > in_right_col) ||
                    (32'(in_bottom_row) >= 32'(eff_rows)) ||
                    (32'(in_right_col) >= 32'(eff_cols));

  always_comb begin
    cmd_data = '0;
    if (in_req_type == REQ_LOAD) begin
      cmd_data.is_load = 1'b1;
      cmd_data.status  = ST_OK;
      cmd_data.has_top = (load_row_r != '0);
      cmd_data.addr0   = ADDR_MAX_W'(32'(load_row_r) * MAX_COLS + 32'(load_col_r));
      cmd_data.addr1   = ADDR_MAX_W'((32'(load_row_r) - 1) * MAX_COLS + 32'(load_col_r));
      cmd_data.run_sum = run_new;
    end else begin
      cmd_data.is_load  = 1'b0;
      cmd_data.has_top  = (in_top_row != '0);
      cmd_data.has_left = (in_left_col != '0);
      if (!ready_r) begin
        cmd_data.status = ST_NOT_READY;
      end else if (rect_bad) begin
        cmd_data.status = ST_BAD_RECT;
      end else begin
        cmd_data.status = ST_OK;
      end
      cmd_data.addr0 = ADDR_MAX_W'(32'(in_bottom_row) * MAX_COLS + 32'(in_right_col));
      cmd_data.addr1 = ADDR_MAX_W'((32'(in_top_row) - 1) * MAX_COLS + 32'(in_right_col));
      cmd_data.addr2 = ADDR_MAX_W'(32'(in_bottom_row) * MAX_COLS + 32'(in_left_col) - 1);
      cmd_data.addr3 = ADDR_MAX_W'((32'(in_top_row) - 1) * MAX_COLS + 32'(in_left_col) - 1);
    end
  end

  always_comb begin
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    run_nxt      = run_r;
    ready_nxt    = ready_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS: begin
          rows_nxt     = cfg_wdata;
          load_row_nxt = '0;
          load_col_nxt = '0;
          run_nxt      = '0;
          ready_nxt    = 1'b0;
        end
        REG_COLS: begin
          cols_nxt     = cfg_wdata;
          load_row_nxt = '0;
          load_col_nxt = '0;
          run_nxt      = '0;
          ready_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (accept && (in_req_type == REQ_LOAD)) begin
      ready_nxt = 1'b0;
      if (col_last) begin
        load_col_nxt = '0;
        run_nxt      = '0;
        if (row_last) begin
          load_row_nxt = '0;
          ready_nxt    = 1'b1;
        end else begin
          load_row_nxt = load_row_r + 1'b1;
        end
      end else begin
        load_col_nxt = load_col_r + 1'b1;
        run_nxt      = run_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= RESET_ROWS;
      cols_r     <= RESET_COLS;
      load_row_r <= '0;
      load_col_r <= '0;
      run_r      <= '0;
      ready_r    <= 1'b0;
    end else begin
      rows_r     <= rows_nxt;
      cols_r     <= cols_nxt;
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      run_r      <= run_nxt;
      ready_r    <= ready_nxt;
    end
  end

endmodule

[sv/sat_back.sv]
// Back end: table memory with two read ports, load writes and four-read rectangle sums.
module sat_back #(
  parameter int MAX_ROWS = sat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sat_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  input  sat_pkg::sat_cmd_t             cmd_data,
  input  logic                          res_full,
  output logic                          res_push,
  output logic [sat_pkg::SUM_W-1:0]     res_sum,
  output logic [sat_pkg::STATUS_W-1:0]  res_status
);

  import sat_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LD   = 4'b0010,
    S_QA   = 4'b0100,
    S_QB   = 4'b1000
  } bk_state_t;

  bk_state_t        st_r, st_nxt;
  sat_cmd_t         cmd_r, cmd_nxt;
  logic [SUM_W-1:0] part_r, part_nxt;
  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd0_r, rd1_r;

  logic             take;
  logic [AW-1:0]    ra0, ra1, wa;
  logic             we;
  logic [SUM_W-1:0] wd;
  logic [SUM_W-1:0] top_term, left_term, diag_term, q_sum;

  assign top_term  = cmd_r.has_top ? rd1_r : '0;
  assign left_term = cmd_r.has_left ? rd0_r : '0;
  assign diag_term = (cmd_r.has_top && cmd_r.has_left) ? rd1_r : '0;
  assign q_sum     = part_r - left_term + diag_term;
  assign wa        = cmd_r.addr0[AW-1:0];
  assign wd        = cmd_r.run_sum + top_term;
  assign res_sum    = (cmd_r.status == ST_OK) ? q_sum : '0;
  assign res_status = cmd_r.status;
  assign cmd_pop    = take;

  always_comb begin
    take     = 1'b0;
    st_nxt   = st_r;
    cmd_nxt  = cmd_r;
    part_nxt = part_r;
    res_push = 1'b0;
    we       = 1'b0;
    ra0      = cmd_r.addr2[AW-1:0];
    ra1      = cmd_r.addr3[AW-1:0];
    case (st_r)
      S_IDLE: begin
        take = !cmd_empty;
      end
      S_LD: begin
        we     = 1'b1;
        st_nxt = S_IDLE;
      end
      S_QA: begin
        part_nxt = rd0_r - top_term;
        st_nxt   = S_QB;
      end
      S_QB: begin
        if (!res_full) begin
          res_push = 1'b1;
          take     = !cmd_empty;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (take) begin
      cmd_nxt = cmd_data;
      ra0     = cmd_data.addr0[AW-1:0];
      ra1     = cmd_data.addr1[AW-1:0];
      if (cmd_data.is_load) begin
        st_nxt = S_LD;
      end else if (cmd_data.status == ST_OK) begin
        st_nxt = S_QA;
      end else begin
        st_nxt = S_QB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    part_r <= part_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

endmodule

[sv/summed_area_table_query_unit.sv]
// Top level of the summed-area table query unit.
//
// Input channel (in_push / in_full): a load (in_req_type 0) stores the next
// matrix element in raster order; a query (in_req_type 1) asks for the sum of
// the inclusive rectangle given by its four corners. Loads give no result,
// every query gives exactly one, in input order.
// Result channel (out_empty / out_pop): the oldest result sits on out_rect_sum
// and out_query_status while out_empty is low.
// Configuration (cfg_valid / cfg_ready, cfg_ready always high): index 0 sets
// the rows in use, index 1 the columns in use; either write restarts loading.
// A front end classifies items and a four-entry command queue feeds the back
// end, which owns the table memory (one write port, two read ports).
// The back end handles one command at a time: a load reads the entry above,
// then writes; a query issues two read pairs on the two read ports, then
// waits while the output queue is full.
// Reset clears the position, the running sum and the ready flag and sets both
// sizes to 64; the table memory is not cleared.
// When the receiver stalls, results collect in a two-entry output queue, then
// the command queue fills and in_full rises.
module summed_area_table_query_unit #(
  parameter int MAX_ROWS   = sat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = sat_pkg::DEF_MAX_COLS,
  parameter int ELEM_WIDTH = sat_pkg::DEF_ELEM_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sat_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sat_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_req_type,
  input  logic signed [sat_pkg::ELEM_IN_W-1:0] in_elem_value,
  input  logic [sat_pkg::COORD_W-1:0]          in_top_row,
  input  logic [sat_pkg::COORD_W-1:0]          in_left_col,
  input  logic [sat_pkg::COORD_W-1:0]          in_bottom_row,
  input  logic [sat_pkg::COORD_W-1:0]          in_right_col,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [sat_pkg::SUM_W-1:0]     out_rect_sum,
  output logic [sat_pkg::STATUS_W-1:0]         out_query_status
);

  import sat_pkg::*;

  localparam int CMD_W = $bits(sat_cmd_t);
  localparam int RES_W = SUM_W + STATUS_W;

  sat_cmd_t            fe_cmd;
  logic                fe_push;
  logic                cq_full, cq_empty, cq_pop;
  logic [CMD_W-1:0]    cq_data;
  logic                res_push, rq_full;
  logic [SUM_W-1:0]    res_sum;
  logic [STATUS_W-1:0] res_status;
  logic [RES_W-1:0]    rq_data;

  sat_front #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_req_type   (in_req_type),
    .in_elem_value (in_elem_value),
    .in_top_row    (in_top_row),
    .in_left_col   (in_left_col),
    .in_bottom_row (in_bottom_row),
    .in_right_col  (in_right_col),
    .cmd_push      (fe_push),
    .cmd_data      (fe_cmd),
    .cmd_full      (cq_full)
  );

  sat_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_push),
    .push_data (fe_cmd),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_data  (cq_data),
    .empty     (cq_empty)
  );

  sat_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cq_empty),
    .cmd_pop    (cq_pop),
    .cmd_data   (sat_cmd_t'(cq_data)),
    .res_full   (rq_full),
    .res_push   (res_push),
    .res_sum    (res_sum),
    .res_status (res_status)
  );

  sat_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data ({res_status, res_sum}),
    .full      (rq_full),
    .pop       (out_pop),
    .pop_data  (rq_data),
    .empty     (out_empty)
  );

  assign out_rect_sum     = rq_data[SUM_W-1:0];
  assign out_query_status = rq_data[RES_W-1:SUM_W];

endmodule

[sv/sat_checker.sv]
// Port-level checks for the summed-area table query unit, bound to the top level.
module sat_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_ready,
  input logic                                 in_full,
  input logic                                 out_empty,
  input logic                                 out_pop,
  input logic signed [sat_pkg::SUM_W-1:0]     out_rect_sum,
  input logic [sat_pkg::STATUS_W-1:0]         out_query_status
);

  import sat_pkg::*;

  a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (out_empty && !in_full && cfg_ready))
    else $error("queues not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_rect_sum) && $stable(out_query_status)))
    else $error("stalled result changed");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_query_status != ST_OK)) |-> (out_rect_sum == '0))
    else $error("flagged result carries a nonzero sum");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |->
      ((out_query_status == ST_OK) || (out_query_status == ST_BAD_RECT) ||
       (out_query_status == ST_NOT_READY)))
    else $error("undefined status code");

endmodule

bind summed_area_table_query_unit sat_checker u_sat_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_ready        (cfg_ready),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_rect_sum     (out_rect_sum),
  .out_query_status (out_query_status)
);
